// File: rtl/core/bgb_pkg.sv
// bgb_pkg: shared types, field layout and constants of the glyph blitter
// used by bgb_cell_walker, bgb_pixel_stage and bitmap_glyph_blitter
`default_nettype none

package bgb_pkg;

    // default geometry
    localparam int FB_WIDTH_DEF    = 320;
    localparam int FB_HEIGHT_DEF   = 240;
    localparam int GLYPH_COUNT_DEF = 96;
    localparam int GLYPH_ROWS_DEF  = 7;
    localparam int GLYPH_COLS_DEF  = 5;

    // input item layout in tdata, lowest bit first
    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int CODE_W  = 8;
    localparam int MODE_W  = 2;
    localparam int COLOR_W = 16;
    localparam int LG_W    = 7;
    localparam int LR_W    = 3;
    localparam int BITS_W  = 8;

    localparam int OFF_X    = 0;
    localparam int OFF_Y    = OFF_X + X_W;
    localparam int OFF_CODE = OFF_Y + Y_W;
    localparam int OFF_MODE = OFF_CODE + CODE_W;
    localparam int OFF_FG   = OFF_MODE + MODE_W;
    localparam int OFF_BG   = OFF_FG + COLOR_W;
    localparam int OFF_LG   = OFF_BG + COLOR_W;
    localparam int OFF_LR   = OFF_LG + LG_W;
    localparam int OFF_BITS = OFF_LR + LR_W;
    localparam int IN_USED  = OFF_BITS + BITS_W;
    localparam int IN_DATA_W = ((IN_USED + 7) / 8) * 8;

    // result item layout in tdata
    localparam int OUT_USED   = X_W + Y_W + COLOR_W;
    localparam int OUT_DATA_W = ((OUT_USED + 7) / 8) * 8;

    // item kinds carried in tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    localparam logic [CODE_W-1:0] CODE_BASE = 8'h20;
    localparam int MODE_OPAQUE_BIT  = 0;
    localparam int MODE_REVERSE_BIT = 1;
    localparam logic [2:0] FONT_MSB = 3'd7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FROW,
        ST_CELLS,
        ST_DONE
    } t_state;

    // walker to pixel stage
    typedef struct packed {
        logic               clr;
        logic               issue;
        logic               emit;
        logic               set;
        logic [MODE_W-1:0]  mode;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic [X_W-1:0]     px;
        logic [Y_W-1:0]     py;
        logic               fin;
    } t_cell_req;

    // pixel stage to walker
    typedef struct packed {
        logic adv;
        logic idle;
    } t_pix_sts;

endpackage

`default_nettype wire

// File: rtl/core/bitmap_glyph_blitter.sv
// glyph blitter top: a load item, or a draw item with a bad code, leaves the input open;
// a valid draw item closes it for the first font row fetch, a visit to each cell
// (GLYPH_ROWS*GLYPH_COLS = 35, next row fetched with a row's last cell) and the drain;
// each pixel is held until the next one or the end of the walk, for the last flag
// reset: synchronous; then a clearing pass over max(FB_WIDTH*FB_HEIGHT, font depth)
// addresses (76800 at defaults) zeroes both stores while no item is taken
`default_nettype none

module bitmap_glyph_blitter #(
    parameter int FB_WIDTH    = bgb_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT   = bgb_pkg::FB_HEIGHT_DEF,
    parameter int GLYPH_COUNT = bgb_pkg::GLYPH_COUNT_DEF,
    parameter int GLYPH_ROWS  = bgb_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_COLS  = bgb_pkg::GLYPH_COLS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // pos_x[8:0] pos_y[16:9] char_code[24:17] mode[26:25] fg_color[42:27]
    // bg_color[58:43] load_glyph[65:59] load_row[68:66] row_bits[76:69] zero[79:77]
    input  wire logic [bgb_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // func[0]
    input  wire logic                            i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // pix_x[8:0] pix_y[16:9] pix_value[32:17] zero[39:33]
    output logic [bgb_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);

    localparam int AW = $clog2(FB_WIDTH * FB_HEIGHT);

    bgb_pkg::t_cell_req w_req;
    bgb_pkg::t_pix_sts  w_sts;
    logic [AW-1:0]      w_addr;

    bgb_cell_walker #(
        .FB_WIDTH    (FB_WIDTH),
        .FB_HEIGHT   (FB_HEIGHT),
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COLS  (GLYPH_COLS)
    ) u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_s_func  (i_s_axis_tuser),
        .i_s_data  (i_s_axis_tdata),
        .i_sts     (w_sts),
        .o_req     (w_req),
        .o_addr    (w_addr)
    );

    bgb_pixel_stage #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_pixel (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_addr    (w_addr),
        .o_sts     (w_sts),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata),
        .o_m_last  (o_m_axis_tlast)
    );

    // no item is taken in the cycle after reset: the clearing pass runs first
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("item taken while stores are being cleared");

    // emitted pixels are always on screen
    a_pixel_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((32'(o_m_axis_tdata[8:0]) < FB_WIDTH)
                             && (32'(o_m_axis_tdata[16:9]) < FB_HEIGHT)))
        else $error("pixel outside the frame emitted");

    // a finished draw with the pixel path drained reopens the input
    a_done_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req.fin && w_sts.idle) |=> o_s_axis_tready)
        else $error("input not reopened after draw finished");

    // clearing and the cell walk never share the frame port
    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.clr |-> !w_req.issue)
        else $error("frame clear overlaps a cell access");

endmodule

`default_nettype wire

// File: rtl/core/bgb_cell_walker.sv
// bgb_cell_walker: control sequencer, font store and cell address generation
// depends on bgb_pkg
`default_nettype none

module bgb_cell_walker #(
    parameter int FB_WIDTH    = bgb_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT   = bgb_pkg::FB_HEIGHT_DEF,
    parameter int GLYPH_COUNT = bgb_pkg::GLYPH_COUNT_DEF,
    parameter int GLYPH_ROWS  = bgb_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_COLS  = bgb_pkg::GLYPH_COLS_DEF,
    localparam int AW = $clog2(FB_WIDTH * FB_HEIGHT)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_valid,
    output logic                                o_s_ready,
    input  wire logic                           i_s_func,
    input  wire logic [bgb_pkg::IN_DATA_W-1:0]  i_s_data,
    input  wire bgb_pkg::t_pix_sts              i_sts,
    output bgb_pkg::t_cell_req                  o_req,
    output logic [AW-1:0]                       o_addr
);

    localparam int FRAME_DEPTH = FB_WIDTH * FB_HEIGHT;
    localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int FAW = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;
    localparam int CLEAR_LEN = (FRAME_DEPTH > FONT_DEPTH) ? FRAME_DEPTH : FONT_DEPTH;
    localparam int CW  = $clog2(CLEAR_LEN);
    localparam int RCW = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
    localparam int CCW = (GLYPH_COLS > 1) ? $clog2(GLYPH_COLS) : 1;

    bgb_pkg::t_state r_state, n_state;

    logic [CW-1:0]                   r_cnt;
    logic [RCW-1:0]                  r_row;
    logic [CCW-1:0]                  r_col;
    logic [FAW-1:0]                  r_faddr;
    logic [AW-1:0]                   r_base;
    logic [bgb_pkg::X_W-1:0]         r_pos_x;
    logic [bgb_pkg::Y_W-1:0]         r_pos_y;
    logic [bgb_pkg::MODE_W-1:0]      r_mode;
    logic [bgb_pkg::COLOR_W-1:0]     r_fg;
    logic [bgb_pkg::COLOR_W-1:0]     r_bg;
    logic [7:0]                      r_font [FONT_DEPTH];
    logic [7:0]                      r_frd;

    logic [bgb_pkg::X_W-1:0]     in_x;
    logic [bgb_pkg::Y_W-1:0]     in_y;
    logic [bgb_pkg::CODE_W-1:0]  in_code;
    logic [bgb_pkg::MODE_W-1:0]  in_mode;
    logic [bgb_pkg::COLOR_W-1:0] in_fg;
    logic [bgb_pkg::COLOR_W-1:0] in_bg;
    logic [bgb_pkg::LG_W-1:0]    in_lg;
    logic [bgb_pkg::LR_W-1:0]    in_lr;
    logic [bgb_pkg::BITS_W-1:0]  in_bits;

    logic [bgb_pkg::CODE_W-1:0]  glyph;
    logic                        s_fire;
    logic                        code_ok;
    logic                        load_ok;
    logic [FAW-1:0]              load_addr;
    logic [FAW-1:0]              glyph_addr;
    logic [AW-1:0]               start_base;
    logic                        last_col;
    logic                        last_row;
    logic [bgb_pkg::X_W:0]       px;
    logic [bgb_pkg::Y_W:0]       py;
    logic                        on_screen;
    logic                        cell_set;
    logic                        issue;
    logic                        prefetch;
    logic                        font_rd;
    logic                        clr_font;
    logic                        clr_frame;

    assign in_x    = i_s_data[bgb_pkg::OFF_X    +: bgb_pkg::X_W];
    assign in_y    = i_s_data[bgb_pkg::OFF_Y    +: bgb_pkg::Y_W];
    assign in_code = i_s_data[bgb_pkg::OFF_CODE +: bgb_pkg::CODE_W];
    assign in_mode = i_s_data[bgb_pkg::OFF_MODE +: bgb_pkg::MODE_W];
    assign in_fg   = i_s_data[bgb_pkg::OFF_FG   +: bgb_pkg::COLOR_W];
    assign in_bg   = i_s_data[bgb_pkg::OFF_BG   +: bgb_pkg::COLOR_W];
    assign in_lg   = i_s_data[bgb_pkg::OFF_LG   +: bgb_pkg::LG_W];
    assign in_lr   = i_s_data[bgb_pkg::OFF_LR   +: bgb_pkg::LR_W];
    assign in_bits = i_s_data[bgb_pkg::OFF_BITS +: bgb_pkg::BITS_W];

    always_comb begin
        logic [31:0] la;
        logic [31:0] ga;
        logic [31:0] sb;
        s_fire  = i_s_valid && (r_state == bgb_pkg::ST_IDLE);
        glyph   = in_code - bgb_pkg::CODE_BASE;
        code_ok = (in_code >= bgb_pkg::CODE_BASE) && (32'(glyph) < GLYPH_COUNT);
        load_ok = (32'(in_lg) < GLYPH_COUNT) && (32'(in_lr) < GLYPH_ROWS);
        la = 32'(in_lg) * GLYPH_ROWS + 32'(in_lr);
        ga = 32'(glyph) * GLYPH_ROWS;
        sb = 32'(in_y) * FB_WIDTH;
        load_addr  = la[FAW-1:0];
        glyph_addr = ga[FAW-1:0];
        start_base = sb[AW-1:0];

        last_col  = (r_col == CCW'(GLYPH_COLS - 1));
        last_row  = (r_row == RCW'(GLYPH_ROWS - 1));
        px        = {1'b0, r_pos_x} + (bgb_pkg::X_W + 1)'(r_col);
        py        = {1'b0, r_pos_y} + (bgb_pkg::Y_W + 1)'(r_row);
        on_screen = (32'(px) < FB_WIDTH) && (32'(py) < FB_HEIGHT);
        cell_set  = r_frd[bgb_pkg::FONT_MSB - 3'(r_col)];

        issue     = (r_state == bgb_pkg::ST_CELLS) && i_sts.adv;
        prefetch  = issue && last_col && !last_row;
        font_rd   = (r_state == bgb_pkg::ST_FROW) || prefetch;
        clr_font  = (r_state == bgb_pkg::ST_CLEAR) && (32'(r_cnt) < FONT_DEPTH);
        clr_frame = (r_state == bgb_pkg::ST_CLEAR) && (32'(r_cnt) < FRAME_DEPTH);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bgb_pkg::ST_CLEAR: begin
                if (32'(r_cnt) == CLEAR_LEN - 1) n_state = bgb_pkg::ST_IDLE;
            end
            bgb_pkg::ST_IDLE: begin
                if (s_fire && (i_s_func == bgb_pkg::FUNC_DRAW) && code_ok) begin
                    n_state = bgb_pkg::ST_FROW;
                end
            end
            bgb_pkg::ST_FROW: begin
                n_state = bgb_pkg::ST_CELLS;
            end
            bgb_pkg::ST_CELLS: begin
                if (issue && last_col && last_row) n_state = bgb_pkg::ST_DONE;
            end
            bgb_pkg::ST_DONE: begin
                if (i_sts.idle) n_state = bgb_pkg::ST_IDLE;
            end
            default: n_state = bgb_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgb_pkg::ST_CLEAR;
            r_cnt   <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == bgb_pkg::ST_CLEAR) r_cnt <= r_cnt + CW'(1);
            if (r_state == bgb_pkg::ST_FROW) begin
                r_row <= '0;
                r_col <= '0;
            end else if (issue) begin
                if (last_col) begin
                    r_col <= '0;
                    if (!last_row) r_row <= r_row + RCW'(1);
                end else begin
                    r_col <= r_col + CCW'(1);
                end
            end
        end
    end

    // draw context and row bookkeeping
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_pos_x <= in_x;
            r_pos_y <= in_y;
            r_mode  <= in_mode;
            r_fg    <= in_fg;
            r_bg    <= in_bg;
            r_faddr <= glyph_addr;
            r_base  <= start_base;
        end else begin
            if (font_rd) r_faddr <= r_faddr + FAW'(1);
            if (prefetch) r_base <= r_base + AW'(FB_WIDTH);
        end
    end

    // font store: clear, load and row fetch
    always_ff @(posedge i_clk) begin
        if (clr_font) begin
            r_font[r_cnt[FAW-1:0]] <= '0;
        end else if (s_fire && (i_s_func == bgb_pkg::FUNC_LOAD) && load_ok) begin
            r_font[load_addr] <= in_bits;
        end
        if (font_rd) r_frd <= r_font[r_faddr];
    end

    always_comb begin
        o_s_ready   = (r_state == bgb_pkg::ST_IDLE);
        o_req.clr   = clr_frame;
        o_req.issue = issue;
        o_req.emit  = on_screen && (cell_set || r_mode[bgb_pkg::MODE_OPAQUE_BIT]);
        o_req.set   = cell_set;
        o_req.mode  = r_mode;
        o_req.fg    = r_fg;
        o_req.bg    = r_bg;
        o_req.px    = px[bgb_pkg::X_W-1:0];
        o_req.py    = py[bgb_pkg::Y_W-1:0];
        o_req.fin   = (r_state == bgb_pkg::ST_DONE);
        o_addr      = (r_state == bgb_pkg::ST_CLEAR) ? r_cnt[AW-1:0] : r_base + AW'(px);
    end

endmodule

`default_nettype wire

// File: rtl/core/bgb_pixel_stage.sv
// bgb_pixel_stage: frame store read-modify-write, last-pixel hold and output register
// depends on bgb_pkg
`default_nettype none

module bgb_pixel_stage #(
    parameter int FB_WIDTH  = bgb_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT = bgb_pkg::FB_HEIGHT_DEF,
    localparam int AW = $clog2(FB_WIDTH * FB_HEIGHT)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bgb_pkg::t_cell_req              i_req,
    input  wire logic [AW-1:0]                   i_addr,
    output bgb_pkg::t_pix_sts                    o_sts,
    output logic                                 o_m_valid,
    input  wire logic                            i_m_ready,
    output logic [bgb_pkg::OUT_DATA_W-1:0]       o_m_data,
    output logic                                 o_m_last
);

    localparam int FRAME_DEPTH = FB_WIDTH * FB_HEIGHT;
    localparam int PEND_W = bgb_pkg::OUT_USED;

    logic [bgb_pkg::COLOR_W-1:0] r_frame [FRAME_DEPTH];
    logic [bgb_pkg::COLOR_W-1:0] r_rd;

    logic                        r_b_valid;
    logic [AW-1:0]               r_b_addr;
    logic                        r_b_set;
    logic [bgb_pkg::MODE_W-1:0]  r_b_mode;
    logic [bgb_pkg::COLOR_W-1:0] r_b_fg;
    logic [bgb_pkg::COLOR_W-1:0] r_b_bg;
    logic [bgb_pkg::X_W-1:0]     r_b_px;
    logic [bgb_pkg::Y_W-1:0]     r_b_py;

    logic                        r_p_valid;
    logic [PEND_W-1:0]           r_p_data;
    logic                        r_o_valid;
    logic [PEND_W-1:0]           r_o_data;
    logic                        r_o_last;

    logic                        out_free;
    logic                        b_fire;
    logic                        adv;
    logic                        move;
    logic                        rev;
    logic [bgb_pkg::COLOR_W-1:0] value;

    always_comb begin
        out_free = !r_o_valid || i_m_ready;
        b_fire   = r_b_valid && (!r_p_valid || out_free);
        adv      = !r_b_valid || b_fire;
        // the held pixel goes out once the next one shows up or the walk is over
        move     = r_p_valid && out_free && (b_fire || (i_req.fin && !r_b_valid));
        rev      = r_b_mode[bgb_pkg::MODE_REVERSE_BIT];
        if (r_b_set) begin
            value = rev ? ~r_rd : r_b_fg;
        end else begin
            value = rev ? r_b_fg : r_b_bg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.clr) begin
            r_frame[i_addr] <= '0;
        end else if (b_fire) begin
            r_frame[r_b_addr] <= value;
        end
        if (i_req.issue && i_req.emit && adv) r_rd <= r_frame[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (adv) r_b_valid <= i_req.issue && i_req.emit;
            if (b_fire) begin
                r_p_valid <= 1'b1;
            end else if (move) begin
                r_p_valid <= 1'b0;
            end
            if (move) begin
                r_o_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_req.issue) begin
            r_b_addr <= i_addr;
            r_b_set  <= i_req.set;
            r_b_mode <= i_req.mode;
            r_b_fg   <= i_req.fg;
            r_b_bg   <= i_req.bg;
            r_b_px   <= i_req.px;
            r_b_py   <= i_req.py;
        end
        if (b_fire) r_p_data <= {value, r_b_py, r_b_px};
        if (move) begin
            r_o_data <= r_p_data;
            r_o_last <= !b_fire;
        end
    end

    assign o_sts.adv  = adv;
    assign o_sts.idle = !r_b_valid && !r_p_valid;
    assign o_m_valid  = r_o_valid;
    assign o_m_data   = {(bgb_pkg::OUT_DATA_W - PEND_W)'(0), r_o_data};
    assign o_m_last   = r_o_last;

endmodule

`default_nettype wire

// File: dv/bitmap_glyph_blitter_test.sv
// bitmap_glyph_blitter_test: self-checking bench for the glyph blitter, keeps its own copy
// of the font and frame stores and checks every emitted pixel write in order
// depends on bgb_pkg and bitmap_glyph_blitter

module bitmap_glyph_blitter_test;

    localparam int FB_W    = bgb_pkg::FB_WIDTH_DEF;
    localparam int FB_H    = bgb_pkg::FB_HEIGHT_DEF;
    localparam int GLYPH_N = bgb_pkg::GLYPH_COUNT_DEF;
    localparam int GLYPH_R = bgb_pkg::GLYPH_ROWS_DEF;
    localparam int GLYPH_C = bgb_pkg::GLYPH_COLS_DEF;
    localparam int IN_W    = bgb_pkg::IN_DATA_W;
    localparam int OUT_W   = bgb_pkg::OUT_DATA_W;
    localparam int CHAR_BASE = int'(bgb_pkg::CODE_BASE);

    localparam int PIX_X_OFF = 0;
    localparam int PIX_Y_OFF = bgb_pkg::X_W;
    localparam int PIX_V_OFF = bgb_pkg::X_W + bgb_pkg::Y_W;

    localparam int MODE_TRANSPARENT = 0;
    localparam int MODE_OPAQUE      = 1;
    localparam int MODE_REVERSE     = 2;
    localparam int MODE_REV_OPAQUE  = 3;

    // the clearing pass after reset takes no item
    localparam int STALL_LIMIT  = 320000;
    localparam int ITEM_TARGET  = 500;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic                          fn;
        logic [bgb_pkg::X_W-1:0]       x;
        logic [bgb_pkg::Y_W-1:0]       y;
        logic [bgb_pkg::CODE_W-1:0]    code;
        logic [bgb_pkg::MODE_W-1:0]    mode;
        logic [bgb_pkg::COLOR_W-1:0]   fg;
        logic [bgb_pkg::COLOR_W-1:0]   bg;
        logic [bgb_pkg::LG_W-1:0]      lg;
        logic [bgb_pkg::LR_W-1:0]      lr;
        logic [bgb_pkg::BITS_W-1:0]    bits;
    } t_glyph_cmd;

    typedef struct {
        bit [bgb_pkg::X_W-1:0]     x;
        bit [bgb_pkg::Y_W-1:0]     y;
        bit [bgb_pkg::COLOR_W-1:0] value;
        bit                        last;
    } t_pixel;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata = '0;
    logic             i_s_axis_tuser = bgb_pkg::FUNC_LOAD;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             o_m_axis_tlast;

    bit [7:0]  font_copy [0:GLYPH_N*GLYPH_R-1];
    bit [15:0] frame_copy [0:FB_W*FB_H-1];
    t_pixel    pixel_q [$];

    int error_count = 0;
    int items_sent = 0;
    int stall_cycles = 0;
    int sink_hold = 0;
    bit src_gaps_on = 1'b0;
    bit sink_stalls_on = 1'b0;
    t_pixel seen;

    bitmap_glyph_blitter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mostly short idle spans, now and then a long one
    function automatic int idle_span();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    endtask

    // walks the glyph exactly as the block does and queues every pixel write
    task automatic predict_item(input t_glyph_cmd c);
        int g;
        int r;
        int k;
        int px;
        int py;
        int addr;
        int n;
        bit [7:0] rowv;
        bit [15:0] v;
        t_pixel p;
        n = 0;
        if (c.fn == bgb_pkg::FUNC_LOAD) begin
            if (int'(c.lg) < GLYPH_N && int'(c.lr) < GLYPH_R) begin
                font_copy[int'(c.lg) * GLYPH_R + int'(c.lr)] = c.bits;
            end
            return;
        end
        if (c.code < bgb_pkg::CODE_BASE) begin
            return;
        end
        g = int'(c.code) - CHAR_BASE;
        if (g >= GLYPH_N) begin
            return;
        end
        for (r = 0; r < GLYPH_R; r++) begin
            rowv = font_copy[g * GLYPH_R + r];
            py = int'(c.y) + r;
            for (k = 0; k < GLYPH_C; k++) begin
                px = int'(c.x) + k;
                if (px >= FB_W || py >= FB_H) begin
                    continue;
                end
                addr = py * FB_W + px;
                if (rowv[7 - k]) begin
                    v = c.mode[bgb_pkg::MODE_REVERSE_BIT] ? ~frame_copy[addr] : c.fg;
                end else if (!c.mode[bgb_pkg::MODE_OPAQUE_BIT]) begin
                    continue;
                end else begin
                    v = c.mode[bgb_pkg::MODE_REVERSE_BIT] ? c.fg : c.bg;
                end
                frame_copy[addr] = v;
                p.x = px[bgb_pkg::X_W-1:0];
                p.y = py[bgb_pkg::Y_W-1:0];
                p.value = v;
                p.last = 1'b0;
                pixel_q.push_back(p);
                n++;
            end
        end
        if (n > 0) begin
            pixel_q[$].last = 1'b1;
        end
    endtask

    task automatic send_item(input t_glyph_cmd c);
        logic [IN_W-1:0] d;
        int gap;
        d = '0;
        d[bgb_pkg::OFF_X    +: bgb_pkg::X_W]     = c.x;
        d[bgb_pkg::OFF_Y    +: bgb_pkg::Y_W]     = c.y;
        d[bgb_pkg::OFF_CODE +: bgb_pkg::CODE_W]  = c.code;
        d[bgb_pkg::OFF_MODE +: bgb_pkg::MODE_W]  = c.mode;
        d[bgb_pkg::OFF_FG   +: bgb_pkg::COLOR_W] = c.fg;
        d[bgb_pkg::OFF_BG   +: bgb_pkg::COLOR_W] = c.bg;
        d[bgb_pkg::OFF_LG   +: bgb_pkg::LG_W]    = c.lg;
        d[bgb_pkg::OFF_LR   +: bgb_pkg::LR_W]    = c.lr;
        d[bgb_pkg::OFF_BITS +: bgb_pkg::BITS_W]  = c.bits;
        gap = (src_gaps_on && $urandom_range(0, 9) < 4) ? idle_span() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tuser  <= c.fn;
        i_s_axis_tdata  <= d;
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_sent++;
        predict_item(c);
    endtask

    // fields unused by the item kind carry random values
    task automatic put_font_row(input int glyph, input int row, input int bits);
        logic [95:0] junk;
        t_glyph_cmd c;
        junk   = {$urandom, $urandom, $urandom};
        c.fn   = bgb_pkg::FUNC_LOAD;
        c.x    = junk[bgb_pkg::OFF_X    +: bgb_pkg::X_W];
        c.y    = junk[bgb_pkg::OFF_Y    +: bgb_pkg::Y_W];
        c.code = junk[bgb_pkg::OFF_CODE +: bgb_pkg::CODE_W];
        c.mode = junk[bgb_pkg::OFF_MODE +: bgb_pkg::MODE_W];
        c.fg   = junk[bgb_pkg::OFF_FG   +: bgb_pkg::COLOR_W];
        c.bg   = junk[bgb_pkg::OFF_BG   +: bgb_pkg::COLOR_W];
        c.lg   = glyph[bgb_pkg::LG_W-1:0];
        c.lr   = row[bgb_pkg::LR_W-1:0];
        c.bits = bits[bgb_pkg::BITS_W-1:0];
        send_item(c);
    endtask

    task automatic draw_char(input int code, input int x, input int y, input int mode,
                             input int fg, input int bg);
        logic [95:0] junk;
        t_glyph_cmd c;
        junk   = {$urandom, $urandom, $urandom};
        c.fn   = bgb_pkg::FUNC_DRAW;
        c.x    = x[bgb_pkg::X_W-1:0];
        c.y    = y[bgb_pkg::Y_W-1:0];
        c.code = code[bgb_pkg::CODE_W-1:0];
        c.mode = mode[bgb_pkg::MODE_W-1:0];
        c.fg   = fg[bgb_pkg::COLOR_W-1:0];
        c.bg   = bg[bgb_pkg::COLOR_W-1:0];
        c.lg   = junk[bgb_pkg::OFF_LG   +: bgb_pkg::LG_W];
        c.lr   = junk[bgb_pkg::OFF_LR   +: bgb_pkg::LR_W];
        c.bits = junk[bgb_pkg::OFF_BITS +: bgb_pkg::BITS_W];
        send_item(c);
    endtask

    task automatic wait_pixels_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
    endtask

    // glyph for space gets rows that hit each column and the ignored low bits
    task automatic test_font_rows();
        put_font_row(0, 0, 'hFF);
        put_font_row(0, 1, 'h80);
        put_font_row(0, 2, 'h08);
        put_font_row(0, 3, 'h07);
        put_font_row(0, 4, 'hAA);
        put_font_row(0, 5, 'h55);
        put_font_row(0, 6, 'hF8);
        draw_char(CHAR_BASE, 0, 0, MODE_TRANSPARENT, 'hFFFF, 'h0000);
    endtask

    task automatic test_draw_modes();
        // read-modify-write of pixels just written, with the source held off first
        wait_pixels_drained();
        draw_char(CHAR_BASE, 0, 0, MODE_REV_OPAQUE, 'h0000, 'hFFFF);
        draw_char(CHAR_BASE, 10, 5, MODE_OPAQUE, 'h0000, 'hFFFF);
        draw_char(CHAR_BASE, 10, 5, MODE_REVERSE, 'h1234, 'h5678);
    endtask

    task automatic test_screen_edges();
        draw_char(CHAR_BASE, FB_W - 3, FB_H - 3, MODE_OPAQUE, 'hF800, 'h07E0);
        draw_char(CHAR_BASE, FB_W - 1, FB_H - 1, MODE_REVERSE, 'h001F, 'h0000);
        draw_char(CHAR_BASE, 511, 255, MODE_OPAQUE, 'hFFFF, 'hFFFF);
    endtask

    task automatic test_code_range();
        draw_char(CHAR_BASE - 1, 40, 40, MODE_OPAQUE, 'hAAAA, 'h5555);
        draw_char('h00, 40, 40, MODE_OPAQUE, 'hAAAA, 'h5555);
        draw_char(CHAR_BASE + GLYPH_N, 40, 40, MODE_OPAQUE, 'hAAAA, 'h5555);
        draw_char('hFF, 40, 40, MODE_OPAQUE, 'hAAAA, 'h5555);
        draw_char(CHAR_BASE + GLYPH_N - 1, 40, 40, MODE_OPAQUE, 'hAAAA, 'h5555);
    endtask

    // loads past the font end must leave the store alone
    task automatic test_bad_font_loads();
        put_font_row(GLYPH_N, 0, 'hFF);
        put_font_row(127, GLYPH_R - 1, 'hFF);
        put_font_row(GLYPH_N - 1, GLYPH_R, 'hFF);
        put_font_row(GLYPH_N - 1, GLYPH_R - 1, 'hFF);
        draw_char(CHAR_BASE + GLYPH_N - 1, 60, 60, MODE_TRANSPARENT, 'hC3C3, 'h0000);
    endtask

    task automatic test_random_text();
        int g;
        int r;
        int reps;
        int x;
        int y;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 4) == 0) begin
                src_gaps_on = !src_gaps_on;
            end
            if ($urandom_range(0, 4) == 0) begin
                sink_stalls_on = !sink_stalls_on;
            end
            if ($urandom_range(0, 99) < 20) begin
                if ($urandom_range(0, 1) == 0) begin
                    put_font_row($urandom_range(0, 127), $urandom_range(0, 7),
                                 $urandom_range(0, 255));
                end else begin
                    draw_char($urandom_range(0, 255), $urandom_range(0, 511),
                              $urandom_range(0, 255), $urandom_range(0, 3), $urandom, $urandom);
                end
            end else begin
                g = $urandom_range(0, GLYPH_N - 1);
                // now and then a row load is dropped from the sequence
                for (r = 0; r < GLYPH_R; r++) begin
                    if ($urandom_range(0, 9) != 0) begin
                        put_font_row(g, r, $urandom_range(0, 255));
                    end
                end
                reps = $urandom_range(1, 3);
                x = 0;
                y = 0;
                for (r = 0; r < reps; r++) begin
                    if (r == 0 || $urandom_range(0, 1) == 0) begin
                        case ($urandom_range(0, 9))
                            7: begin
                                x = $urandom_range(FB_W - 8, FB_W + 10);
                                y = $urandom_range(0, FB_H - 1);
                            end
                            8: begin
                                x = $urandom_range(0, FB_W - 1);
                                y = $urandom_range(FB_H - 10, 255);
                            end
                            9: begin
                                x = $urandom_range(0, 511);
                                y = $urandom_range(0, 255);
                            end
                            default: begin
                                x = $urandom_range(0, FB_W - GLYPH_C);
                                y = $urandom_range(0, FB_H - GLYPH_R);
                            end
                        endcase
                    end
                    draw_char(g + CHAR_BASE, x, y, $urandom_range(0, 3), $urandom, $urandom);
                end
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (!sink_stalls_on) begin
            i_m_axis_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold--;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            sink_hold = idle_span() - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            seen.x = o_m_axis_tdata[PIX_X_OFF +: bgb_pkg::X_W];
            seen.y = o_m_axis_tdata[PIX_Y_OFF +: bgb_pkg::Y_W];
            seen.value = o_m_axis_tdata[PIX_V_OFF +: bgb_pkg::COLOR_W];
            seen.last = o_m_axis_tlast;
            if (pixel_q.size() == 0) begin
                report_mismatch("pixel with nothing pending, x", int'(seen.x), 0);
            end else begin
                if (seen.x != pixel_q[0].x) begin
                    report_mismatch("pix_x", int'(seen.x), int'(pixel_q[0].x));
                end
                if (seen.y != pixel_q[0].y) begin
                    report_mismatch("pix_y", int'(seen.y), int'(pixel_q[0].y));
                end
                if (seen.value != pixel_q[0].value) begin
                    report_mismatch("pix_value", int'(seen.value), int'(pixel_q[0].value));
                end
                if (seen.last != pixel_q[0].last) begin
                    report_mismatch("last", int'(seen.last), int'(pixel_q[0].last));
                end
                void'(pixel_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_font_rows();
        test_draw_modes();
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        test_screen_edges();
        test_code_range();
        test_bad_font_loads();
        test_random_text();
        wait_pixels_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
